/* src/fortran_record_deframer_defines.svh */
// Assertion helpers for the record deframer.
// Both expect signals named clock and reset in the scope of use.
`ifndef FORTRAN_RECORD_DEFRAMER_DEFINES_SVH
`define FORTRAN_RECORD_DEFRAMER_DEFINES_SVH

// Check a consequence in the same cycle as its cause.
`define FRD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the cycle after its cause.
`define FRD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/frd_pkg.sv */
package frd_pkg;

   // Largest payload group that is reversed as one element.
   localparam int MAX_GROUP  = 8;
   // At most this many results come out of one input word.
   localparam int RESULT_CAP = 8;
   localparam int GROUP_CAP  = (MAX_GROUP < RESULT_CAP) ? MAX_GROUP : RESULT_CAP;
   localparam int IDX_W      = $clog2(GROUP_CAP);
   localparam int FILL_W     = $clog2(GROUP_CAP + 1);

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_IS_64 = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SWAP_GROUP   = 1'd1;

   localparam logic [3:0] MARKER_BYTES_32 = 4'd4;
   localparam logic [3:0] MARKER_BYTES_64 = 4'd8;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_MISMATCH  = 2'd1;
   localparam logic [1:0] STAT_BAD_GROUP = 2'd2;
   localparam logic [1:0] STAT_TRUNCATED = 2'd3;

   typedef logic [FILL_W-1:0] fill_type;
   typedef logic [IDX_W-1:0]  idx_type;

   typedef enum logic [2:0] {
      PH_HEADER  = 3'b001,
      PH_PAYLOAD = 3'b010,
      PH_TRAILER = 3'b100
   } phase_type;

   typedef enum logic [1:0] {
      ST_TAKE = 2'b01,
      ST_EMIT = 2'b10
   } ctl_state_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       stream_end;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] out_byte;
      logic       record_last;
      logic [1:0] status;
      logic       run_last;
   } rsp_type;

   typedef struct packed {
      logic take;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic out_busy;
      logic flush_multi;
      logic emit_last;
   } sts_type;

endpackage

/* src/frd_ctrl.sv */
module frd_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  frd_pkg::sts_type sts,
   output frd_pkg::cmd_type cmd
);

   frd_pkg::ctl_state_type state_ff, state_in;

   always_comb begin
      cmd.take  = (state_ff == frd_pkg::ST_TAKE) && req_valid && !sts.out_busy;
      cmd.emit  = (state_ff == frd_pkg::ST_EMIT) && !sts.out_busy;
      req_stall = !((state_ff == frd_pkg::ST_TAKE) && !sts.out_busy);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         frd_pkg::ST_TAKE: begin
            if (cmd.take && sts.flush_multi) begin
               state_in = frd_pkg::ST_EMIT;
            end
         end
         frd_pkg::ST_EMIT: begin
            if (cmd.emit && sts.emit_last) begin
               state_in = frd_pkg::ST_TAKE;
            end
         end
         default: begin
            state_in = frd_pkg::ST_TAKE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= frd_pkg::ST_TAKE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* src/frd_datapath.sv */
module frd_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  frd_pkg::req_type                req_data,
   input  logic                            csr_wr_en,
   input  logic [frd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [frd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  frd_pkg::cmd_type                cmd,
   output frd_pkg::sts_type                sts,
   output logic                            rsp_valid,
   output frd_pkg::rsp_type                rsp_data,
   input  logic                            rsp_stall
);

   logic                 hdr64_ff;
   logic [3:0]           swap_group_ff;

   frd_pkg::phase_type   phase_ff, phase_in;
   logic [3:0]           mcount_ff, mcount_in;
   logic [63:0]          hdr_len_ff, hdr_len_in;
   logic [63:0]          remain_ff, remain_in;
   logic [63:0]          tlr_len_ff, tlr_len_in;
   frd_pkg::fill_type    fill_ff, fill_in;
   frd_pkg::idx_type     idx_ff, idx_in;
   logic [7:0]           store_ff [frd_pkg::GROUP_CAP];
   logic                 store_we;

   logic                 rsp_valid_ff, rsp_valid_in;
   frd_pkg::rsp_type     rsp_data_ff, rsp_data_in;
   logic                 out_load;

   frd_pkg::fill_type    grp_size;
   frd_pkg::fill_type    fill_new;
   logic [3:0]           mlen;
   logic [3:0]           mcount_next;
   logic                 marker_done;
   logic [63:0]          marker_acc;
   logic [63:0]          marker_val;
   logic                 swapped;

   // Shift a marker byte in: big-endian when swapping, else into its lane.
   function automatic logic [63:0] add_marker_byte(logic [63:0] acc, logic [7:0] b,
                                                   logic [3:0] pos, logic swp);
      logic [63:0] lane;
      lane = {56'd0, b} << {pos[2:0], 3'b000};
      if (swp) begin
         return {acc[55:0], b};
      end
      return acc | lane;
   endfunction

   always_comb begin
      swapped = (swap_group_ff != 4'd0);
      if (swap_group_ff == 4'd0) begin
         grp_size = frd_pkg::fill_type'(1);
      end else if (swap_group_ff > 4'(frd_pkg::GROUP_CAP)) begin
         grp_size = frd_pkg::fill_type'(frd_pkg::GROUP_CAP);
      end else begin
         grp_size = frd_pkg::fill_type'(swap_group_ff);
      end
      fill_new    = fill_ff + frd_pkg::fill_type'(1);
      mlen        = hdr64_ff ? frd_pkg::MARKER_BYTES_64 : frd_pkg::MARKER_BYTES_32;
      mcount_next = mcount_ff + 4'd1;
      marker_done = (mcount_next >= mlen);
      marker_acc  = add_marker_byte((phase_ff == frd_pkg::PH_TRAILER) ? tlr_len_ff
                                                                       : hdr_len_ff,
                                    req_data.data_byte, mcount_ff, swapped);
      marker_val  = hdr64_ff ? marker_acc : {32'd0, marker_acc[31:0]};
   end

   always_comb begin
      sts.out_busy    = rsp_valid_ff && rsp_stall;
      sts.flush_multi = !req_data.stream_end && (phase_ff == frd_pkg::PH_PAYLOAD) &&
                        (fill_new >= grp_size) && (fill_new > frd_pkg::fill_type'(1));
      sts.emit_last   = (idx_ff == frd_pkg::idx_type'(0));
   end

   always_comb begin
      phase_in    = phase_ff;
      mcount_in   = mcount_ff;
      hdr_len_in  = hdr_len_ff;
      remain_in   = remain_ff;
      tlr_len_in  = tlr_len_ff;
      fill_in     = fill_ff;
      idx_in      = idx_ff;
      store_we    = 1'b0;
      out_load    = 1'b0;
      rsp_data_in = rsp_data_ff;

      if (cmd.take) begin
         if (req_data.stream_end) begin
            // A stream end inside a record closes it as truncated.
            if (!((phase_ff == frd_pkg::PH_HEADER) && (mcount_ff == 4'd0))) begin
               out_load    = 1'b1;
               rsp_data_in = '{kind: frd_pkg::KIND_STATUS, out_byte: 8'd0,
                               record_last: 1'b0, status: frd_pkg::STAT_TRUNCATED,
                               run_last: 1'b1};
               phase_in    = frd_pkg::PH_HEADER;
               mcount_in   = 4'd0;
               hdr_len_in  = 64'd0;
               remain_in   = 64'd0;
               tlr_len_in  = 64'd0;
               fill_in     = frd_pkg::fill_type'(0);
            end
         end else begin
            case (phase_ff)
               frd_pkg::PH_PAYLOAD: begin
                  store_we  = 1'b1;
                  remain_in = remain_ff - 64'd1;
                  if (fill_new >= grp_size) begin
                     // Newest byte leads the reversed group; the rest drain later.
                     out_load    = 1'b1;
                     rsp_data_in = '{kind: frd_pkg::KIND_PAYLOAD,
                                     out_byte: req_data.data_byte,
                                     record_last: (fill_new == frd_pkg::fill_type'(1)) &&
                                                  (remain_ff == 64'd1),
                                     status: frd_pkg::STAT_OK,
                                     run_last: (fill_new == frd_pkg::fill_type'(1))};
                     idx_in      = frd_pkg::idx_type'(fill_new - frd_pkg::fill_type'(2));
                     fill_in     = frd_pkg::fill_type'(0);
                  end else begin
                     fill_in = fill_new;
                  end
                  if (remain_ff == 64'd1) begin
                     phase_in   = frd_pkg::PH_TRAILER;
                     mcount_in  = 4'd0;
                     tlr_len_in = 64'd0;
                  end
               end
               frd_pkg::PH_TRAILER: begin
                  if (marker_done) begin
                     out_load    = 1'b1;
                     rsp_data_in = '{kind: frd_pkg::KIND_STATUS, out_byte: 8'd0,
                                     record_last: 1'b0, status: frd_pkg::STAT_OK,
                                     run_last: 1'b1};
                     if (fill_ff != frd_pkg::fill_type'(0)) begin
                        rsp_data_in.status = frd_pkg::STAT_BAD_GROUP;
                     end else if (marker_val != hdr_len_ff) begin
                        rsp_data_in.status = frd_pkg::STAT_MISMATCH;
                     end
                     phase_in   = frd_pkg::PH_HEADER;
                     mcount_in  = 4'd0;
                     hdr_len_in = 64'd0;
                     remain_in  = 64'd0;
                     tlr_len_in = 64'd0;
                     fill_in    = frd_pkg::fill_type'(0);
                  end else begin
                     tlr_len_in = marker_acc;
                     mcount_in  = mcount_next;
                  end
               end
               default: begin
                  if (marker_done) begin
                     hdr_len_in = marker_val;
                     remain_in  = marker_val;
                     mcount_in  = 4'd0;
                     fill_in    = frd_pkg::fill_type'(0);
                     tlr_len_in = 64'd0;
                     phase_in   = (marker_val != 64'd0) ? frd_pkg::PH_PAYLOAD
                                                        : frd_pkg::PH_TRAILER;
                  end else begin
                     hdr_len_in = marker_acc;
                     mcount_in  = mcount_next;
                  end
               end
            endcase
         end
      end else if (cmd.emit) begin
         out_load    = 1'b1;
         rsp_data_in = '{kind: frd_pkg::KIND_PAYLOAD, out_byte: store_ff[idx_ff],
                         record_last: (idx_ff == frd_pkg::idx_type'(0)) &&
                                      (remain_ff == 64'd0),
                         status: frd_pkg::STAT_OK,
                         run_last: (idx_ff == frd_pkg::idx_type'(0))};
         idx_in      = idx_ff - frd_pkg::idx_type'(1);
      end

      rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr64_ff      <= 1'b0;
         swap_group_ff <= 4'd0;
         phase_ff      <= frd_pkg::PH_HEADER;
         mcount_ff     <= 4'd0;
         hdr_len_ff    <= 64'd0;
         remain_ff     <= 64'd0;
         tlr_len_ff    <= 64'd0;
         fill_ff       <= frd_pkg::fill_type'(0);
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en && (csr_index == frd_pkg::CSR_HEADER_IS_64)) begin
            hdr64_ff <= csr_wdata[0];
         end
         if (csr_wr_en && (csr_index == frd_pkg::CSR_SWAP_GROUP)) begin
            swap_group_ff <= csr_wdata;
         end
         phase_ff     <= phase_in;
         mcount_ff    <= mcount_in;
         hdr_len_ff   <= hdr_len_in;
         remain_ff    <= remain_in;
         tlr_len_ff   <= tlr_len_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
      if (store_we) begin
         store_ff[fill_ff[frd_pkg::IDX_W-1:0]] <= req_data.data_byte;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* src/fortran_record_deframer.sv */
// Deframer for sequential unformatted records. Each record on req_data is a
// 4- or 8-byte length header (csr register header_is_64), that many payload
// bytes and a trailer that should repeat the header. Markers are read
// little-endian, or big-endian once swap_group is nonzero; payload bytes are
// reversed within groups of swap_group bytes (0 or 1 passes them through,
// larger values are capped at 8). Every payload byte comes out as one rsp
// word of kind payload; the trailer closes the record with one status word:
// ok, trailer mismatch, bad group multiple (the bytes of an unfinished group
// are dropped) or truncated, the last when stream_end arrives inside a
// record. run_last marks the last rsp word caused by one req word.
// A req word that completes a group of n bytes is followed by a drain in
// which the controller sends the rest of the group, one byte a cycle while
// rsp_stall is low, from the group store's single read port; req_stall
// stays high meanwhile. The rsp output is registered, so a new req word is
// taken while the previous rsp word waits, as long as it is not held by
// rsp_stall. Write the csr registers only while the block is idle. There is
// no clearing pass after reset.
`include "fortran_record_deframer_defines.svh"

module fortran_record_deframer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  frd_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output frd_pkg::rsp_type                rsp_data,
   input  logic                            csr_wr_en,
   input  logic [frd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [frd_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   frd_pkg::cmd_type cmd;
   frd_pkg::sts_type sts;

   // Sequence word acceptance and the group drain.
   frd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Record state, marker assembly, group store and rsp register.
   frd_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

   // Never take a word and drain the group store in the same cycle.
   `FRD_ASSERT_NOW(a_take_xor_emit, cmd.take, !cmd.emit, "take during group drain")
   // A multi-byte group flush must hold off the next req word.
   `FRD_ASSERT_NEXT(a_flush_stalls, cmd.take && sts.flush_multi, req_stall, "no stall after flush")
   // A status word always ends the run of its req word.
   `FRD_ASSERT_NOW(a_status_last, rsp_valid && (rsp_data.kind == frd_pkg::KIND_STATUS), rsp_data.run_last, "status without run_last")
   // The last byte of a record is the last word of its group.
   `FRD_ASSERT_NOW(a_record_last, rsp_valid && rsp_data.record_last, rsp_data.run_last, "record_last without run_last")

endmodule
